// ===== src/rlm_pkg.sv =====
// Shared constants and types for the RGB LED matrix PWM scanner.
`timescale 1ns / 1ps

package rlm_pkg;

  localparam int ROWS        = 8;
  localparam int COLUMNS     = 8;
  localparam int STORE_DEPTH = 64;
  localparam int IDX_W       = 6;
  localparam int COLOR_W     = 6;
  localparam int POS_W       = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [15:0] LEVEL_TABLE_RESET = 16'hFFE9;
  localparam logic [7:0]  BYTE_OFF          = 8'hFF;
  localparam logic [7:0]  ROW_TOP           = 8'h80;
  localparam logic [7:0]  COL_NONE          = 8'h00;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SCAN  = 1'b1;

  // One scan step handed from the front to the back.
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               col_wrap;
  } job_t;

endpackage

// ===== src/rlm_front.sv =====
// Front end: takes input beats, owns the pixel store and the scan position.
`timescale 1ns / 1ps

module rlm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_cmd,
  input  logic [rlm_pkg::IDX_W-1:0]   in_pixel_index,
  input  logic [rlm_pkg::COLOR_W-1:0] in_pixel_color,
  input  logic [rlm_pkg::QCNT_W-1:0]  q_count_i,
  output logic                        q_push_o,
  output rlm_pkg::job_t               q_job_o
);

  logic [rlm_pkg::COLOR_W-1:0] mem [rlm_pkg::STORE_DEPTH];
  logic [rlm_pkg::STORE_DEPTH-1:0] valid_r;

  logic [rlm_pkg::POS_W-1:0] scan_row_r, scan_row_nxt;
  logic [rlm_pkg::POS_W-1:0] scan_col_r, scan_col_nxt;

  logic                        s1_valid_r;
  logic [rlm_pkg::POS_W-1:0]   s1_row_r, s1_col_r;
  logic                        s1_wrap_r;
  logic [rlm_pkg::COLOR_W-1:0] rd_data_r;
  logic                        rd_hit_r;

  logic                        accept, do_scan, do_write;
  logic                        row_wrap, col_wrap;
  logic [rlm_pkg::IDX_W-1:0]   scan_addr;
  logic [rlm_pkg::QCNT_W-1:0]  pending;

  // Count the beat in the read stage as already queued.
  assign pending  = q_count_i + rlm_pkg::QCNT_W'(s1_valid_r);
  assign in_full  = (pending >= rlm_pkg::QCNT_W'(rlm_pkg::QUEUE_DEPTH));
  assign accept   = in_push && !in_full;
  assign do_scan  = accept && (in_cmd == rlm_pkg::CMD_SCAN);
  assign do_write = accept && (in_cmd == rlm_pkg::CMD_WRITE);

  assign scan_addr = rlm_pkg::IDX_W'(scan_row_r) * rlm_pkg::IDX_W'(rlm_pkg::COLUMNS)
                   + rlm_pkg::IDX_W'(scan_col_r);
  assign row_wrap  = ({1'b0, scan_row_r} + 4'd1) >= 4'(rlm_pkg::ROWS);
  assign col_wrap  = row_wrap && (({1'b0, scan_col_r} + 4'd1) >= 4'(rlm_pkg::COLUMNS));

  always_comb begin
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    if (do_scan) begin
      if (row_wrap) begin
        scan_row_nxt = '0;
        scan_col_nxt = col_wrap ? '0 : scan_col_r + 1'b1;
      end else begin
        scan_row_nxt = scan_row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      scan_row_r <= '0;
      scan_col_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (do_write) begin
        valid_r[in_pixel_index] <= 1'b1;
      end
      scan_row_r <= scan_row_nxt;
      scan_col_r <= scan_col_nxt;
      s1_valid_r <= do_scan;
    end
  end

  // Pixel store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[in_pixel_index] <= in_pixel_color;
    end
    if (do_scan) begin
      rd_data_r <= mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_scan) begin
      rd_hit_r  <= valid_r[scan_addr];
      s1_row_r  <= scan_row_r;
      s1_col_r  <= scan_col_r;
      s1_wrap_r <= col_wrap;
    end
  end

  assign q_push_o         = s1_valid_r;
  assign q_job_o.color    = rd_hit_r ? rd_data_r : '0;
  assign q_job_o.row      = s1_row_r;
  assign q_job_o.col      = s1_col_r;
  assign q_job_o.col_wrap = s1_wrap_r;

  a_scan_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
    do_scan |=> s1_valid_r)
    else $error("scan beat did not reach the read stage");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (q_count_i < rlm_pkg::QCNT_W'(rlm_pkg::QUEUE_DEPTH)))
    else $error("job pushed into a full queue");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (4'(scan_row_r) < 4'(rlm_pkg::ROWS)) && (4'(scan_col_r) < 4'(rlm_pkg::COLUMNS)))
    else $error("scan position out of range");

endmodule

// ===== src/rlm_job_queue.sv =====
// Short queue of scan jobs between the front and the back.
`timescale 1ns / 1ps

module rlm_job_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_i,
  input  rlm_pkg::job_t              job_i,
  input  logic                       pop_i,
  output rlm_pkg::job_t              head_o,
  output logic                       nonempty_o,
  output logic [rlm_pkg::QCNT_W-1:0] count_o
);

  rlm_pkg::job_t entries [rlm_pkg::QUEUE_DEPTH];

  logic [rlm_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [rlm_pkg::QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + rlm_pkg::QCNT_W'(push_i) - rlm_pkg::QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entries[wr_ptr_r] <= job_i;
    end
  end

  assign head_o     = entries[rd_ptr_r];
  assign nonempty_o = (count_r != '0);
  assign count_o    = count_r;

endmodule

// ===== src/rlm_back.sv =====
// Back end: expands each scan job into colour packets and the frame blank.
`timescale 1ns / 1ps

module rlm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [15:0]   level_table_i,
  input  logic          q_nonempty_i,
  input  rlm_pkg::job_t q_head_i,
  output logic          q_pop_o,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [7:0]    out_red_byte,
  output logic [7:0]    out_blue_byte,
  output logic [7:0]    out_green_byte,
  output logic [7:0]    out_column_byte,
  output logic          out_last
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RED   = 5'b00010,
    S_GREEN = 5'b00100,
    S_BLUE  = 5'b01000,
    S_OFF   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  rlm_pkg::job_t job_r, job_nxt;
  logic [rlm_pkg::POS_W-1:0] frame_r, frame_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic [7:0] col_r, col_nxt;
  logic       last_r, last_nxt;

  logic       slot_free;
  logic [1:0] thr;
  logic [7:0] lit, col_sel;

  assign slot_free = !out_valid_r || out_pop;
  assign thr       = 2'(level_table_i >> {frame_r, 1'b0});
  assign lit       = ~(rlm_pkg::ROW_TOP >> job_r.row);
  assign col_sel   = 8'h01 << job_r.col;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    frame_nxt     = frame_r;
    q_pop_o       = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    col_nxt       = col_r;
    last_nxt      = last_r;

    case (state_r)
      S_IDLE: begin
        if (q_nonempty_i) begin
          q_pop_o   = 1'b1;
          job_nxt   = q_head_i;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          red_nxt   = (job_r.color[5:4] >= thr) ? lit : rlm_pkg::BYTE_OFF;
          green_nxt = rlm_pkg::BYTE_OFF;
          blue_nxt  = rlm_pkg::BYTE_OFF;
          col_nxt   = col_sel;
          last_nxt  = 1'b0;
          state_nxt = S_GREEN;
        end
      end
      S_GREEN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          red_nxt   = rlm_pkg::BYTE_OFF;
          green_nxt = (job_r.color[3:2] >= thr) ? lit : rlm_pkg::BYTE_OFF;
          blue_nxt  = rlm_pkg::BYTE_OFF;
          col_nxt   = col_sel;
          last_nxt  = 1'b0;
          state_nxt = S_BLUE;
        end
      end
      S_BLUE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          red_nxt   = rlm_pkg::BYTE_OFF;
          green_nxt = rlm_pkg::BYTE_OFF;
          blue_nxt  = (job_r.color[1:0] >= thr) ? lit : rlm_pkg::BYTE_OFF;
          col_nxt   = col_sel;
          last_nxt  = !job_r.col_wrap;
          if (job_r.col_wrap) begin
            state_nxt = S_OFF;
          end else if (q_nonempty_i) begin
            q_pop_o   = 1'b1;
            job_nxt   = q_head_i;
            state_nxt = S_RED;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OFF: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          red_nxt   = rlm_pkg::BYTE_OFF;
          green_nxt = rlm_pkg::BYTE_OFF;
          blue_nxt  = rlm_pkg::BYTE_OFF;
          col_nxt   = rlm_pkg::COL_NONE;
          last_nxt  = 1'b1;
          frame_nxt = frame_r + 1'b1;
          if (q_nonempty_i) begin
            q_pop_o   = 1'b1;
            job_nxt   = q_head_i;
            state_nxt = S_RED;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    col_r   <= col_nxt;
    last_r  <= last_nxt;
  end

  assign out_empty       = !out_valid_r;
  assign out_red_byte    = red_r;
  assign out_green_byte  = green_r;
  assign out_blue_byte   = blue_r;
  assign out_column_byte = col_r;
  assign out_last        = last_r;

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_o |-> q_nonempty_i)
    else $error("job popped from an empty queue");

  a_blank_after_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OFF) |-> job_r.col_wrap)
    else $error("frame blank without a frame wrap");

  a_frame_steps_on_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_r != $past(frame_r)) |-> ($past(state_r) == S_OFF))
    else $error("frame count moved outside the blank packet");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> out_valid_r)
    else $error("waiting result dropped");

endmodule

// ===== src/rgb_led_matrix_pwm_scanner.sv =====
// Top level of the RGB LED matrix PWM scanner.
`timescale 1ns / 1ps

// Single-LED PWM scanner for an 8x8 RGB matrix fed through four chained
// shift-register bytes. Push a write beat (in_cmd = 0) to store a 6-bit
// colour at in_pixel_index; it produces no result. Push a scan beat
// (in_cmd = 1) to light the next pixel in column-major order: it yields
// red, green and blue packets (one component each, active-low row bytes,
// one-hot column byte), and on the last pixel of a frame a fourth all-off
// packet that also steps the 3-bit frame counter. out_last marks the final
// packet of each scan beat. A component is lit when its 2-bit level reaches
// the frame's threshold in cfg_data's table. The back end sends one packet
// per cycle while results are popped, so a scan beat occupies it for three
// packets, four at a frame wrap; that packet serializer sets the sustained
// rate. The front end reads the pixel store (registered read) and hands jobs
// over through a four-entry queue, so writes and scans keep flowing until it
// fills while the back end works or the result side stalls. The pixel store
// reads as dark right out of reset through per-pixel valid bits; no
// clearing pass is needed. Write cfg_data only while the block is idle.
module rgb_led_matrix_pwm_scanner (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_cmd,
  input  logic [rlm_pkg::IDX_W-1:0]   in_pixel_index,
  input  logic [rlm_pkg::COLOR_W-1:0] in_pixel_color,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [7:0]                  out_red_byte,
  output logic [7:0]                  out_blue_byte,
  output logic [7:0]                  out_green_byte,
  output logic [7:0]                  out_column_byte,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [15:0]                 cfg_data
);

  logic [15:0] level_table_r;

  logic                       q_push, q_pop, q_nonempty;
  logic [rlm_pkg::QCNT_W-1:0] q_count;
  rlm_pkg::job_t              q_job, q_head;

  // Hold the threshold table; load it on a config beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_table_r <= rlm_pkg::LEVEL_TABLE_RESET;
    end else if (cfg_we) begin
      level_table_r <= cfg_data;
    end
  end

  rlm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cmd         (in_cmd),
    .in_pixel_index (in_pixel_index),
    .in_pixel_color (in_pixel_color),
    .q_count_i      (q_count),
    .q_push_o       (q_push),
    .q_job_o        (q_job)
  );

  rlm_job_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (q_push),
    .job_i      (q_job),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .nonempty_o (q_nonempty),
    .count_o    (q_count)
  );

  rlm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .level_table_i   (level_table_r),
    .q_nonempty_i    (q_nonempty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_red_byte    (out_red_byte),
    .out_blue_byte   (out_blue_byte),
    .out_green_byte  (out_green_byte),
    .out_column_byte (out_column_byte),
    .out_last        (out_last)
  );

endmodule

// ===== sim/tb_rgb_led_matrix_pwm_scanner.sv =====
// Testbench for the RGB LED matrix PWM scanner: directed and random beats vs a predictor.
`timescale 1ns / 1ps

module tb_rgb_led_matrix_pwm_scanner;

  // One packet as it leaves the scanner.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] column;
    logic       last;
  } packet_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_push = 1'b0;
  logic                        in_full;
  logic                        in_cmd = rlm_pkg::CMD_WRITE;
  logic [rlm_pkg::IDX_W-1:0]   in_pixel_index = '0;
  logic [rlm_pkg::COLOR_W-1:0] in_pixel_color = '0;
  logic                        out_empty;
  logic                        out_pop = 1'b0;
  logic [7:0]                  out_red_byte;
  logic [7:0]                  out_blue_byte;
  logic [7:0]                  out_green_byte;
  logic [7:0]                  out_column_byte;
  logic                        out_last;
  logic                        cfg_we = 1'b0;
  logic [15:0]                 cfg_data = '0;

  // Predictor state: the scanner as it should look after every accepted beat.
  logic [rlm_pkg::COLOR_W-1:0] pixel_mirror [rlm_pkg::STORE_DEPTH];
  logic [15:0]                 level_thresholds;
  logic [rlm_pkg::POS_W-1:0]   row_q;
  logic [rlm_pkg::POS_W-1:0]   col_q;
  logic [rlm_pkg::POS_W-1:0]   frame_q;

  // Packets predicted but not yet popped, oldest first.
  packet_t pending_packets [$];
  packet_t oldest_packet;

  int errors = 0;
  int push_idle_pct = 0;
  int pop_stall_pct = 0;
  int stall_left = 0;

  rgb_led_matrix_pwm_scanner dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_cmd          (in_cmd),
    .in_pixel_index  (in_pixel_index),
    .in_pixel_color  (in_pixel_color),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_red_byte    (out_red_byte),
    .out_blue_byte   (out_blue_byte),
    .out_green_byte  (out_green_byte),
    .out_column_byte (out_column_byte),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length for either side: mostly none, else short, now and then long.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Advance the predictor by one accepted beat and queue the packets it causes.
  task automatic predict_beat(input logic cmd, input logic [rlm_pkg::IDX_W-1:0] idx,
                              input logic [rlm_pkg::COLOR_W-1:0] color);
    logic [rlm_pkg::COLOR_W-1:0] pix;
    logic [1:0]                  thr;
    logic [7:0]                  lit;
    logic [7:0]                  colsel;
    logic                        row_wrap;
    logic                        col_wrap;
    packet_t                     pkt;
    if (cmd == rlm_pkg::CMD_WRITE) begin
      // Writes land in the store and produce nothing on the result side.
      pixel_mirror[idx] = color;
    end else begin
      pix    = pixel_mirror[{row_q, col_q}];
      thr    = level_thresholds[{frame_q, 1'b0} +: 2];
      lit    = ~(rlm_pkg::ROW_TOP >> row_q);
      colsel = 8'h01 << col_q;
      row_wrap = (int'(row_q) + 1 >= rlm_pkg::ROWS);
      col_wrap = row_wrap && (int'(col_q) + 1 >= rlm_pkg::COLUMNS);

      // Red, green, blue: each packet lights at most its own component.
      pkt = '{red: (pix[5:4] >= thr) ? lit : rlm_pkg::BYTE_OFF,
              blue: rlm_pkg::BYTE_OFF, green: rlm_pkg::BYTE_OFF,
              column: colsel, last: 1'b0};
      pending_packets.push_back(pkt);
      pkt = '{red: rlm_pkg::BYTE_OFF, blue: rlm_pkg::BYTE_OFF,
              green: (pix[3:2] >= thr) ? lit : rlm_pkg::BYTE_OFF,
              column: colsel, last: 1'b0};
      pending_packets.push_back(pkt);
      pkt = '{red: rlm_pkg::BYTE_OFF,
              blue: (pix[1:0] >= thr) ? lit : rlm_pkg::BYTE_OFF,
              green: rlm_pkg::BYTE_OFF, column: colsel, last: !col_wrap};
      pending_packets.push_back(pkt);

      // Column-major walk: row inner, column outer.
      if (row_wrap) begin
        row_q = '0;
        col_q = col_wrap ? '0 : col_q + 1'b1;
      end else begin
        row_q = row_q + 1'b1;
      end

      // End of frame: blank packet, then step the frame counter.
      if (col_wrap) begin
        pkt = '{red: rlm_pkg::BYTE_OFF, blue: rlm_pkg::BYTE_OFF,
                green: rlm_pkg::BYTE_OFF, column: rlm_pkg::COL_NONE, last: 1'b1};
        pending_packets.push_back(pkt);
        frame_q = frame_q + 1'b1;
      end
    end
  endtask

  // Offer one beat, hold it until accepted, then maybe idle for a while.
  task automatic send_beat(input logic cmd, input logic [rlm_pkg::IDX_W-1:0] idx,
                           input logic [rlm_pkg::COLOR_W-1:0] color);
    int gap;
    in_push        <= 1'b1;
    in_cmd         <= cmd;
    in_pixel_index <= idx;
    in_pixel_color <= color;
    do @(posedge clk); while (in_full);
    predict_beat(cmd, idx, color);
    gap = pick_gap(push_idle_pct);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_scan();
    send_beat(rlm_pkg::CMD_SCAN, rlm_pkg::IDX_W'($urandom), rlm_pkg::COLOR_W'($urandom));
  endtask

  // Stop pushing and wait until every predicted packet has been popped. Writes
  // leave nothing to wait on, so keep idling after the drain to let them land too.
  task automatic wait_idle();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_packets.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Call only while idle.
  task automatic write_level_table(input logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    level_thresholds = value;
  endtask

  function automatic void check_field(input string name, input logic [7:0] got,
                                      input logic [7:0] want);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  // Result side: check each popped beat, then pick the next pop with random stalls.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_packets.size() == 0) begin
        $error("packet popped with none expected: col %h last %b",
               out_column_byte, out_last);
        errors++;
      end else begin
        oldest_packet = pending_packets.pop_front();
        check_field("red_byte", out_red_byte, oldest_packet.red);
        check_field("blue_byte", out_blue_byte, oldest_packet.blue);
        check_field("green_byte", out_green_byte, oldest_packet.green);
        check_field("column_byte", out_column_byte, oldest_packet.column);
        check_field("last", {7'b0, out_last}, {7'b0, oldest_packet.last});
      end
    end
    if (stall_left > 0) begin
      out_pop <= 1'b0;
      stall_left--;
    end else begin
      out_pop <= 1'b1;
      stall_left = pick_gap(pop_stall_pct);
    end
  end

  // Store reads dark out of reset, and frame 0 of the reset table needs level 1.
  task automatic test_dark_after_reset();
    repeat (2) send_scan();
  endtask

  // Fill rows 2..7 of column 0 with level extremes and mixes, touch both ends
  // of the address range, then scan down to the column wrap.
  task automatic test_pixel_writes();
    send_beat(rlm_pkg::CMD_WRITE, 6'd16, 6'h3F);
    send_beat(rlm_pkg::CMD_WRITE, 6'd24, 6'h2A);
    send_beat(rlm_pkg::CMD_WRITE, 6'd32, 6'h15);
    send_beat(rlm_pkg::CMD_WRITE, 6'd40, 6'h30);
    send_beat(rlm_pkg::CMD_WRITE, 6'd48, 6'h0C);
    send_beat(rlm_pkg::CMD_WRITE, 6'd56, 6'h03);
    send_beat(rlm_pkg::CMD_WRITE, 6'd0, 6'h3F);
    send_beat(rlm_pkg::CMD_WRITE, 6'd63, 6'h3F);
    repeat (6) send_scan();
  endtask

  // Zero threshold: even dark pixels light.
  task automatic test_threshold_zero();
    wait_idle();
    write_level_table(16'h0000);
    repeat (3) send_scan();
  endtask

  // Top threshold: only full-level components light.
  task automatic test_threshold_max();
    wait_idle();
    write_level_table(16'hFFFF);
    send_beat(rlm_pkg::CMD_WRITE, 6'd25, 6'h3F);
    send_beat(rlm_pkg::CMD_WRITE, 6'd33, 6'h2A);
    repeat (2) send_scan();
  endtask

  // Mostly scans with random writes between, under one table setting and one
  // idle profile. Draining first also makes the sender pause until all is out.
  task automatic test_random_mix(input int count, input logic [15:0] table_value,
                                 input int idle_pct, input int stall_pct);
    wait_idle();
    write_level_table(table_value);
    push_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    repeat (count) begin
      if ($urandom_range(9) < 8) send_scan();
      else send_beat(rlm_pkg::CMD_WRITE, rlm_pkg::IDX_W'($urandom),
                     rlm_pkg::COLOR_W'($urandom));
    end
  endtask

  // Scan through the next frame wrap under stalls, so the blank packet and the
  // frame step show up with a random table.
  task automatic test_frame_rollover();
    logic [rlm_pkg::POS_W-1:0] start_frame;
    wait_idle();
    write_level_table(16'($urandom));
    push_idle_pct = 20;
    pop_stall_pct = 20;
    start_frame = frame_q;
    do send_scan(); while (frame_q == start_frame);
  endtask

  initial begin
    foreach (pixel_mirror[i]) pixel_mirror[i] = '0;
    level_thresholds = rlm_pkg::LEVEL_TABLE_RESET;
    row_q   = '0;
    col_q   = '0;
    frame_q = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_dark_after_reset();
    test_pixel_writes();
    test_threshold_zero();
    test_threshold_max();
    test_random_mix(80, 16'($urandom), 0, 0);
    test_random_mix(80, rlm_pkg::LEVEL_TABLE_RESET, 30, 30);
    test_random_mix(80, 16'h5555, 10, 50);
    test_random_mix(80, 16'($urandom), 50, 10);
    test_frame_rollover();

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_packets.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end

endmodule
